>>> rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg - shared definitions for the logic channel capture block
// Sizes, command and register codes, event codes and the decision struct
// passed from the control unit to the top level.
// ----------------------------------------------------------------------------
package lcc_pkg;

	// Sizing
	localparam int BUF_DEPTH   = 1024;
	localparam int BUS_LINES   = 8;
	localparam int SAMPLE_BITS = 12;
	localparam int SLOT_W      = $clog2(BUF_DEPTH);

	// Fixed field widths
	localparam int CMD_W      = 2;
	localparam int TIME_W     = 64;
	localparam int RSLOT_W    = 10;
	localparam int CODE_W     = 12;
	localparam int NUM_VOLT   = 8;
	localparam int VAL_W      = 8;
	localparam int EVT_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int MEM_W      = VAL_W + TIME_W;

	localparam int IN_TDATA_W  = 176;
	localparam int OUT_TDATA_W = 160;

	// Commands
	localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUS_MODE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TH_RISE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TH_FALL   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_MASK = 3'd5;

	localparam logic [CODE_W-1:0] TH_RISE_RST = 12'd2500;
	localparam logic [CODE_W-1:0] TH_FALL_RST = 12'd1500;

	// Edge and level event codes
	localparam logic [EVT_W-1:0] EDGE_NONE = 2'd0;
	localparam logic [EVT_W-1:0] EDGE_RISE = 2'd1;
	localparam logic [EVT_W-1:0] EDGE_FALL = 2'd2;
	localparam logic [EVT_W-1:0] LVL_NONE  = 2'd0;
	localparam logic [EVT_W-1:0] LVL_HIGH  = 2'd1;
	localparam logic [EVT_W-1:0] LVL_LOW   = 2'd2;

	typedef logic [SLOT_W-1:0] slot_t;

	// Decision for one beat
	typedef struct packed {
		logic              rec;
		slot_t             slot;
		logic [VAL_W-1:0]  val;
		logic [EVT_W-1:0]  edge_evt;
		logic [EVT_W-1:0]  level_evt;
		logic              rd;
		logic              rd_ok;
		slot_t             rd_idx;
	} lcc_res_t;

endpackage

>>> rtl/lcc_ram.sv
// ----------------------------------------------------------------------------
// lcc_ram - simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lcc_ram #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = 72
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/lcc_ctrl.sv
// ----------------------------------------------------------------------------
// lcc_ctrl - channel control unit
// Holds the configuration registers and the channel state (level, last bus
// value, last reported level, write slot, fill state) and decides per beat
// what is recorded, reported and whether a read hits a written entry.
// ----------------------------------------------------------------------------
module lcc_ctrl import lcc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_addr,
	input  logic [CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                       accept,
	input  logic [CMD_W-1:0]           command,
	input  logic [RSLOT_W-1:0]         read_slot,
	input  logic [NUM_VOLT-1:0][CODE_W-1:0] volt,
	output lcc_res_t                   res
);

	localparam int RX_W = SLOT_W + RSLOT_W;

	// configuration
	logic                  enabled_q;
	logic                  bus_mode_q;
	logic                  report_q;
	logic [CODE_W-1:0]     th_rise_q;
	logic [CODE_W-1:0]     th_fall_q;
	logic [NUM_VOLT-1:0]   line_mask_q;

	// channel state
	logic                  line_high_q, line_high_d;
	logic [VAL_W-1:0]      last_bus_q, last_bus_d;
	logic [EVT_W-1:0]      last_lvl_q, last_lvl_d;
	slot_t                 wslot_q, wslot_d;
	logic                  full_q, full_d;

	logic [SAMPLE_BITS-1:0] rise, fall, code0;
	logic [VAL_W-1:0]       bus_val;
	slot_t                  next_slot;
	logic [RX_W-1:0]        rslot_ext;
	logic                   in_range;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q   <= 1'b0;
			bus_mode_q  <= 1'b0;
			report_q    <= 1'b0;
			th_rise_q   <= TH_RISE_RST;
			th_fall_q   <= TH_FALL_RST;
			line_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ENABLED:   enabled_q   <= cfg_wdata[0];
				REG_BUS_MODE:  bus_mode_q  <= cfg_wdata[0];
				REG_REPORT:    report_q    <= cfg_wdata[0];
				REG_TH_RISE:   th_rise_q   <= cfg_wdata;
				REG_TH_FALL:   th_fall_q   <= cfg_wdata;
				REG_LINE_MASK: line_mask_q <= cfg_wdata[NUM_VOLT-1:0];
				default: ;
			endcase
		end
	end

	// threshold compares
	always_comb begin
		rise    = th_rise_q[SAMPLE_BITS-1:0];
		fall    = th_fall_q[SAMPLE_BITS-1:0];
		code0   = volt[0][SAMPLE_BITS-1:0];
		bus_val = '0;
		for (int n = 0; n < BUS_LINES; n++) begin
			bus_val[n] = line_mask_q[n] && (volt[n][SAMPLE_BITS-1:0] > rise);
		end
	end

	// ring advance and read hit: slots 1..wslot are written, all once wrapped
	assign next_slot = (wslot_q == SLOT_W'(BUF_DEPTH - 1)) ? '0 : wslot_q + 1'b1;
	assign rslot_ext = RX_W'(read_slot);
	assign in_range  = rslot_ext < RX_W'(BUF_DEPTH);

	// per-beat decision
	always_comb begin
		res         = '0;
		res.rd_idx  = rslot_ext[SLOT_W-1:0];
		line_high_d = line_high_q;
		last_bus_d  = last_bus_q;
		last_lvl_d  = last_lvl_q;
		wslot_d     = wslot_q;
		full_d      = full_q;
		case (command)
			CMD_READ: begin
				res.rd    = 1'b1;
				res.rd_ok = in_range && (full_q ||
					(res.rd_idx != '0 && res.rd_idx <= wslot_q));
			end
			CMD_START: begin
				res.rec       = 1'b1;
				res.slot      = SLOT_W'(1);
				res.level_evt = LVL_LOW;
				wslot_d       = SLOT_W'(1);
				line_high_d   = 1'b0;
				last_bus_d    = '0;
				full_d        = 1'b0;
			end
			CMD_SAMPLE: begin
				if (enabled_q) begin
					if (bus_mode_q) begin
						if (bus_val != last_bus_q) begin
							res.rec    = 1'b1;
							res.val    = bus_val;
							last_bus_d = bus_val;
						end
					end else if (code0 > rise) begin
						if (!line_high_q) begin
							res.rec     = 1'b1;
							res.val     = VAL_W'(1);
							line_high_d = 1'b1;
							if (report_q) res.edge_evt = EDGE_RISE;
						end
						if (report_q && last_lvl_q != LVL_HIGH) begin
							res.level_evt = LVL_HIGH;
							last_lvl_d    = LVL_HIGH;
						end
					end else if (code0 < fall) begin
						if (line_high_q) begin
							res.rec     = 1'b1;
							line_high_d = 1'b0;
							if (report_q) res.edge_evt = EDGE_FALL;
						end
						if (report_q && last_lvl_q != LVL_LOW) begin
							res.level_evt = LVL_LOW;
							last_lvl_d    = LVL_LOW;
						end
					end
					if (res.rec) begin
						res.slot = next_slot;
						wslot_d  = next_slot;
						full_d   = full_q | (next_slot == '0);
					end
				end
			end
			default: ;
		endcase
	end

	// state update on accepted beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_high_q <= 1'b0;
			last_bus_q  <= '0;
			last_lvl_q  <= LVL_NONE;
			wslot_q     <= '0;
			full_q      <= 1'b0;
		end else if (accept) begin
			line_high_q <= line_high_d;
			last_bus_q  <= last_bus_d;
			last_lvl_q  <= last_lvl_d;
			wslot_q     <= wslot_d;
			full_q      <= full_d;
		end
	end

	// start leaves the ring at slot 1, not yet wrapped
	a_start_slot: assert property (@(posedge clk) disable iff (!arst_n)
		accept && command == CMD_START |=> wslot_q == SLOT_W'(1) && !full_q)
		else $error("start did not reset the ring");

	// the ring only counts as full after writing slot 0
	a_full_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full_q) |-> wslot_q == '0)
		else $error("ring marked full without wrapping");

	// an edge report always comes with a recording
	a_edge_rec: assert property (@(posedge clk) disable iff (!arst_n)
		res.edge_evt != EDGE_NONE |-> res.rec)
		else $error("edge reported without a recording");

endmodule

>>> rtl/logic_channel_capture.sv
// ----------------------------------------------------------------------------
// logic_channel_capture - logic-analyzer channel with hysteresis capture
//
//  channel  dir  beat contents (tdata, low bits first)
//  s_*      in   command, sample_time, read_slot, volt_0 .. volt_7
//  m_*      out  wrote_entry, entry_slot, entry_value, entry_time,
//                edge_event, level_event, read_value, read_time
//  cfg_*    in   register index and write data, one write per cycle
//
// One beat per cycle while the output is not stalled; a result goes through
// stage 1 (control decision plus RAM read), then the output register.
// The capture buffer is one RAM of value and time; a start is handled by a
// write slot and a full flag, so reset and start need no clearing pass.
// Reset is asynchronous, active low. A stalled output holds its beat and
// stops the pipeline only once both pipeline registers are full.
// ----------------------------------------------------------------------------
module logic_channel_capture import lcc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// config
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_addr,
	input  logic [CFG_DATA_W-1:0]   cfg_wdata,
	// input stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// command, sample_time, read_slot, volt_0 .. volt_7, zero pad
	input  logic [IN_TDATA_W-1:0]   s_tdata,
	// output stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// wrote_entry, entry_slot, entry_value, entry_time, edge_event,
	// level_event, read_value, read_time, zero pad
	output logic [OUT_TDATA_W-1:0]  m_tdata
);

	localparam int TIME_LO = CMD_W;
	localparam int RSL_LO  = TIME_LO + TIME_W;
	localparam int VOLT_LO = RSL_LO + RSLOT_W;
	localparam int SX_W    = SLOT_W + RSLOT_W;

	logic                    accept;
	logic [CMD_W-1:0]        command;
	logic [TIME_W-1:0]       sample_time;
	logic [RSLOT_W-1:0]      read_slot;
	logic [NUM_VOLT-1:0][CODE_W-1:0] volt;
	lcc_res_t                res;
	logic [MEM_W-1:0]        rdata;
	logic [SX_W-1:0]         slot_ext;

	// stage 1 (RAM read in flight) and output register
	logic                    s1_valid_q;
	logic                    rec_s1;
	logic [RSLOT_W-1:0]      slot_s1;
	logic [VAL_W-1:0]        val_s1;
	logic [TIME_W-1:0]       time_s1;
	logic [EVT_W-1:0]        edge_s1;
	logic [EVT_W-1:0]        level_s1;
	logic                    rd_ok_s1;
	logic                    out_valid_q;
	logic [OUT_TDATA_W-1:0]  out_data_q;
	logic                    out_ld;
	logic                    s1_adv;

	// unpack input beat
	always_comb begin
		command     = s_tdata[CMD_W-1:0];
		sample_time = s_tdata[TIME_LO +: TIME_W];
		read_slot   = s_tdata[RSL_LO +: RSLOT_W];
		for (int n = 0; n < NUM_VOLT; n++) begin
			volt[n] = s_tdata[VOLT_LO + n*CODE_W +: CODE_W];
		end
	end

	// flow control
	assign out_ld   = !out_valid_q || m_tready;
	assign s1_adv   = s1_valid_q && out_ld;
	assign s_tready = !s1_valid_q || out_ld;
	assign accept   = s_tvalid && s_tready;

	lcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.command   (command),
		.read_slot (read_slot),
		.volt      (volt),
		.res       (res)
	);

	lcc_ram #(
		.DEPTH  (BUF_DEPTH),
		.ADDR_W (SLOT_W),
		.DATA_W (MEM_W)
	) u_ram (
		.clk   (clk),
		.we    (accept && res.rec),
		.waddr (res.slot),
		.wdata ({sample_time, res.val}),
		.re    (accept && res.rd),
		.raddr (res.rd_idx),
		.rdata (rdata)
	);

	assign slot_ext = SX_W'(res.slot);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rec_s1   <= res.rec;
			slot_s1  <= slot_ext[RSLOT_W-1:0];
			val_s1   <= res.val;
			time_s1  <= res.rec ? sample_time : '0;
			edge_s1  <= res.edge_evt;
			level_s1 <= res.level_evt;
			rd_ok_s1 <= res.rd_ok;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= s1_valid_q;
		end
	end

	// output register payload, read data joins here
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_data_q <= {1'b0,
				rd_ok_s1 ? rdata[MEM_W-1:VAL_W] : {TIME_W{1'b0}},
				rd_ok_s1 ? rdata[VAL_W-1:0] : {VAL_W{1'b0}},
				level_s1, edge_s1, time_s1, val_s1, slot_s1, rec_s1};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// input stalls only when both pipeline registers hold beats
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> s1_valid_q && out_valid_q)
		else $error("input stalled with room in the pipeline");

endmodule
